@@ sv/ifs_pkg.sv @@
`default_nettype none
package ifs_pkg;

    typedef struct packed {
        logic       byte_present;
        logic [7:0] in_byte;
    } ifs_in_t;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       byte_taken;
        logic       stream_done;
        logic [2:0] error_code;
    } ifs_out_t;

    typedef struct packed {
        logic       lit_valid;
        logic [7:0] lit_byte;
        logic       copy;
        logic       taken;
        logic       done;
        logic [2:0] err;
    } ifs_dec_t;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_LEN       = 3'd1;
    localparam logic [2:0] ERR_RESERVED  = 3'd2;
    localparam logic [2:0] ERR_DYNAMIC   = 3'd3;
    localparam logic [2:0] ERR_CODE      = 3'd4;
    localparam logic [2:0] ERR_DIST_CODE = 3'd5;
    localparam logic [2:0] ERR_TOO_FAR   = 3'd6;

    function automatic logic [8:0] flip9(input logic [8:0] v, input int n);
        logic [8:0] r;
        r = '0;
        for (int i = 0; i < 9; i++) begin
            if (i < n) begin
                r = {r[7:0], v[i]};
            end
        end
        return r;
    endfunction

    function automatic logic [8:0] len_base(input logic [4:0] li);
        case (li)
            5'd0:  len_base = 9'd3;
            5'd1:  len_base = 9'd4;
            5'd2:  len_base = 9'd5;
            5'd3:  len_base = 9'd6;
            5'd4:  len_base = 9'd7;
            5'd5:  len_base = 9'd8;
            5'd6:  len_base = 9'd9;
            5'd7:  len_base = 9'd10;
            5'd8:  len_base = 9'd11;
            5'd9:  len_base = 9'd13;
            5'd10: len_base = 9'd15;
            5'd11: len_base = 9'd17;
            5'd12: len_base = 9'd19;
            5'd13: len_base = 9'd23;
            5'd14: len_base = 9'd27;
            5'd15: len_base = 9'd31;
            5'd16: len_base = 9'd35;
            5'd17: len_base = 9'd43;
            5'd18: len_base = 9'd51;
            5'd19: len_base = 9'd59;
            5'd20: len_base = 9'd67;
            5'd21: len_base = 9'd83;
            5'd22: len_base = 9'd99;
            5'd23: len_base = 9'd115;
            5'd24: len_base = 9'd131;
            5'd25: len_base = 9'd163;
            5'd26: len_base = 9'd195;
            5'd27: len_base = 9'd227;
            default: len_base = 9'd258;
        endcase
    endfunction

    function automatic logic [2:0] len_extra(input logic [4:0] li);
        if (li < 5'd8 || li > 5'd27) begin
            len_extra = 3'd0;
        end else begin
            len_extra = 3'((li - 5'd4) >> 2);
        end
    endfunction

    function automatic logic [15:0] dist_base(input logic [4:0] c);
        case (c)
            5'd0:  dist_base = 16'd1;
            5'd1:  dist_base = 16'd2;
            5'd2:  dist_base = 16'd3;
            5'd3:  dist_base = 16'd4;
            5'd4:  dist_base = 16'd5;
            5'd5:  dist_base = 16'd7;
            5'd6:  dist_base = 16'd9;
            5'd7:  dist_base = 16'd13;
            5'd8:  dist_base = 16'd17;
            5'd9:  dist_base = 16'd25;
            5'd10: dist_base = 16'd33;
            5'd11: dist_base = 16'd49;
            5'd12: dist_base = 16'd65;
            5'd13: dist_base = 16'd97;
            5'd14: dist_base = 16'd129;
            5'd15: dist_base = 16'd193;
            5'd16: dist_base = 16'd257;
            5'd17: dist_base = 16'd385;
            5'd18: dist_base = 16'd513;
            5'd19: dist_base = 16'd769;
            5'd20: dist_base = 16'd1025;
            5'd21: dist_base = 16'd1537;
            5'd22: dist_base = 16'd2049;
            5'd23: dist_base = 16'd3073;
            5'd24: dist_base = 16'd4097;
            5'd25: dist_base = 16'd6145;
            5'd26: dist_base = 16'd8193;
            5'd27: dist_base = 16'd12289;
            5'd28: dist_base = 16'd16385;
            default: dist_base = 16'd24577;
        endcase
    endfunction

    function automatic logic [3:0] dist_extra(input logic [4:0] c);
        if (c < 5'd4) begin
            dist_extra = 4'd0;
        end else begin
            dist_extra = 4'((c - 5'd2) >> 1);
        end
    endfunction

endpackage
`default_nettype wire

@@ sv/ifs_hist.sv @@
`default_nettype none
module ifs_hist #(
    parameter int WINDOW_DEPTH = 32768,
    localparam int AW = $clog2(WINDOW_DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          wen,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          ren,
    input  wire logic [AW-1:0] raddr,
    output logic [7:0]         rdata
);

    logic [7:0] mem [WINDOW_DEPTH];

    always_ff @(posedge aclk) begin
        if (wen) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ren) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ sv/ifs_decode.sv @@
`default_nettype none
module ifs_decode #(
    parameter int WINDOW_DEPTH = 32768,
    localparam int AW = $clog2(WINDOW_DEPTH)
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step,
    input  wire logic            skip_hdr,
    input  wire ifs_pkg::ifs_in_t word_in,
    output ifs_pkg::ifs_dec_t    dec,
    output logic [AW-1:0]        rd_addr,
    output logic [AW-1:0]        wr_addr
);

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_BLKHDR = 3'd1;
    localparam logic [2:0] PH_STLEN  = 3'd2;
    localparam logic [2:0] PH_STDATA = 3'd3;
    localparam logic [2:0] PH_SYM    = 3'd4;
    localparam logic [2:0] PH_DIST   = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;
    localparam logic [2:0] PH_ERR    = 3'd7;

    logic [31:0]   buf_reg, buf_next;
    logic [5:0]    held_reg, held_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW:0]   filled_reg, filled_next;
    logic [15:0]   crem_reg, crem_next;
    logic [14:0]   cdist_reg, cdist_next;
    logic [2:0]    phase_reg, phase_next;
    logic          final_reg, final_next;
    logic [8:0]    plen_reg, plen_next;
    logic [1:0]    hdr_reg, hdr_next;
    logic [2:0]    err_reg, err_next;

    logic [15:0] cd;
    logic [16:0] back;

    always_comb begin
        cd = 16'(cdist_reg) + 16'd1;
        if (cd > 16'(WINDOW_DEPTH)) begin
            cd = 16'(WINDOW_DEPTH);
        end
        back = 17'(wp_reg) + 17'(WINDOW_DEPTH) - 17'(cd);
        if (back >= 17'(WINDOW_DEPTH)) begin
            back = back - 17'(WINDOW_DEPTH);
        end
        rd_addr = back[AW-1:0];
        wr_addr = wp_reg;
    end

    always_comb begin
        logic        put;
        logic [8:0]  c;
        logic [4:0]  li;
        logic [3:0]  e;
        logic [5:0]  need;
        logic [12:0] ext;
        logic [15:0] d;
        logic [2:0]  n;

        buf_next    = buf_reg;
        held_next   = held_reg;
        wp_next     = wp_reg;
        filled_next = filled_reg;
        crem_next   = crem_reg;
        cdist_next  = cdist_reg;
        phase_next  = phase_reg;
        final_next  = final_reg;
        plen_next   = plen_reg;
        hdr_next    = hdr_reg;
        err_next    = err_reg;
        dec         = '0;
        put = 1'b0;
        c = '0;
        li = '0;
        e = '0;
        need = '0;
        ext = '0;
        d = '0;
        n = '0;

        if (phase_next == PH_START) begin
            if (!skip_hdr || hdr_reg == 2'd0) begin
                phase_next = PH_BLKHDR;
            end else if (word_in.byte_present) begin
                dec.taken = 1'b1;
                hdr_next = hdr_reg - 2'd1;
                if (hdr_next == 2'd0) begin
                    phase_next = PH_BLKHDR;
                end
            end
        end
        if (phase_next != PH_START && phase_next != PH_DONE && phase_next != PH_ERR &&
            !dec.taken && word_in.byte_present && held_next <= 6'd24) begin
            buf_next  = buf_next | (32'(word_in.in_byte) << held_next[4:0]);
            held_next = held_next + 6'd8;
            dec.taken = 1'b1;
        end

        case (phase_next)
            PH_BLKHDR: begin
                if (held_next >= 6'd3) begin
                    final_next = buf_next[0];
                    c = 9'(buf_next[2:1]);
                    buf_next = buf_next >> 3;
                    held_next = held_next - 6'd3;
                    case (c[1:0])
                        2'd0: begin
                            n = held_next[2:0];
                            buf_next = buf_next >> n;
                            held_next = held_next - 6'(n);
                            phase_next = PH_STLEN;
                        end
                        2'd1: phase_next = PH_SYM;
                        2'd2: begin
                            err_next = ifs_pkg::ERR_DYNAMIC;
                            phase_next = PH_ERR;
                        end
                        default: begin
                            err_next = ifs_pkg::ERR_RESERVED;
                            phase_next = PH_ERR;
                        end
                    endcase
                end
            end
            PH_STLEN: begin
                if (held_next >= 6'd32) begin
                    if ((buf_next[15:0] ^ buf_next[31:16]) != 16'hFFFF) begin
                        err_next = ifs_pkg::ERR_LEN;
                        phase_next = PH_ERR;
                    end else begin
                        crem_next = buf_next[15:0];
                        if (crem_next == 16'd0) begin
                            phase_next = final_next ? PH_DONE : PH_BLKHDR;
                        end else begin
                            phase_next = PH_STDATA;
                        end
                    end
                    buf_next = '0;
                    held_next = '0;
                end
            end
            PH_STDATA: begin
                if (crem_next == 16'd0) begin
                    phase_next = final_next ? PH_DONE : PH_BLKHDR;
                end else if (held_next >= 6'd8) begin
                    dec.lit_valid = 1'b1;
                    dec.lit_byte = buf_next[7:0];
                    buf_next = buf_next >> 8;
                    held_next = held_next - 6'd8;
                    put = 1'b1;
                    crem_next = crem_next - 16'd1;
                    if (crem_next == 16'd0) begin
                        phase_next = final_next ? PH_DONE : PH_BLKHDR;
                    end
                end
            end
            PH_SYM: begin
                if (crem_next != 16'd0) begin
                    dec.lit_valid = 1'b1;
                    dec.copy = 1'b1;
                    put = 1'b1;
                    crem_next = crem_next - 16'd1;
                end else if (held_next >= 6'd7) begin
                    c = ifs_pkg::flip9(9'(buf_next[6:0]), 7);
                    if (c == 9'd0) begin
                        buf_next = buf_next >> 7;
                        held_next = held_next - 6'd7;
                        phase_next = final_next ? PH_DONE : PH_BLKHDR;
                    end else if (c <= 9'h17) begin
                        li = 5'(c - 9'd1);
                        e = 4'(ifs_pkg::len_extra(li));
                        need = 6'd7 + 6'(e);
                        if (held_next >= need) begin
                            ext = 13'((buf_next >> 7) & ((32'd1 << e) - 32'd1));
                            buf_next = buf_next >> need;
                            held_next = held_next - need;
                            plen_next = ifs_pkg::len_base(li) + 9'(ext);
                            phase_next = PH_DIST;
                        end
                    end else if (held_next >= 6'd8) begin
                        c = ifs_pkg::flip9(9'(buf_next[7:0]), 8);
                        if (c >= 9'h30 && c <= 9'hBF) begin
                            buf_next = buf_next >> 8;
                            held_next = held_next - 6'd8;
                            dec.lit_valid = 1'b1;
                            dec.lit_byte = 8'(c - 9'h30);
                            put = 1'b1;
                        end else if (c >= 9'hC0 && c <= 9'hC5) begin
                            li = 5'(c - 9'hC0 + 9'd23);
                            e = 4'(ifs_pkg::len_extra(li));
                            need = 6'd8 + 6'(e);
                            if (held_next >= need) begin
                                ext = 13'((buf_next >> 8) & ((32'd1 << e) - 32'd1));
                                buf_next = buf_next >> need;
                                held_next = held_next - need;
                                plen_next = ifs_pkg::len_base(li) + 9'(ext);
                                phase_next = PH_DIST;
                            end
                        end else if (c == 9'hC6 || c == 9'hC7) begin
                            err_next = ifs_pkg::ERR_CODE;
                            phase_next = PH_ERR;
                        end else if (held_next >= 6'd9) begin
                            c = ifs_pkg::flip9(buf_next[8:0], 9);
                            buf_next = buf_next >> 9;
                            held_next = held_next - 6'd9;
                            dec.lit_valid = 1'b1;
                            dec.lit_byte = c[7:0];
                            put = 1'b1;
                        end
                    end
                end
            end
            PH_DIST: begin
                if (held_next >= 6'd5) begin
                    c = ifs_pkg::flip9(9'(buf_next[4:0]), 5);
                    if (c >= 9'd30) begin
                        err_next = ifs_pkg::ERR_DIST_CODE;
                        phase_next = PH_ERR;
                    end else begin
                        e = ifs_pkg::dist_extra(c[4:0]);
                        need = 6'd5 + 6'(e);
                        if (held_next >= need) begin
                            ext = 13'((buf_next >> 5) & ((32'd1 << e) - 32'd1));
                            buf_next = buf_next >> need;
                            held_next = held_next - need;
                            d = ifs_pkg::dist_base(c[4:0]) + 16'(ext);
                            if (17'(d) > 17'(filled_reg)) begin
                                err_next = ifs_pkg::ERR_TOO_FAR;
                                phase_next = PH_ERR;
                            end else begin
                                cdist_next = 15'(d - 16'd1);
                                crem_next = 16'(plen_reg);
                                phase_next = PH_SYM;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase

        if (put) begin
            wp_next = (wp_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            if (filled_reg < (AW+1)'(WINDOW_DEPTH)) begin
                filled_next = filled_reg + (AW+1)'(1);
            end
        end
        dec.done = (phase_next == PH_DONE);
        dec.err = err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg    <= '0;
            held_reg   <= '0;
            wp_reg     <= '0;
            filled_reg <= '0;
            crem_reg   <= '0;
            cdist_reg  <= '0;
            phase_reg  <= PH_START;
            final_reg  <= 1'b0;
            plen_reg   <= '0;
            hdr_reg    <= 2'd2;
            err_reg    <= ifs_pkg::ERR_NONE;
        end else if (step) begin
            buf_reg    <= buf_next;
            held_reg   <= held_next;
            wp_reg     <= wp_next;
            filled_reg <= filled_next;
            crem_reg   <= crem_next;
            cdist_reg  <= cdist_next;
            phase_reg  <= phase_next;
            final_reg  <= final_next;
            plen_reg   <= plen_next;
            hdr_reg    <= hdr_next;
            err_reg    <= err_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/inflate_fixed_and_stored.sv @@
// Pipeline: an accepted word's result is registered in the p_ stage and then in
// the m_ output register before it is offered on m_.
// Throughput: one word per cycle unless m_ready stalls, copies included; set by the
// decode step and one history read per word, with same-address forwarding from the write port.
// Reset (aresetn low, synchronous): decoder state, pipeline valids and the
// config register (skip_stream_header = 1) are cleared; history is not.
`default_nettype none
module inflate_fixed_and_stored #(
    parameter int WINDOW_DEPTH = 32768
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic             cfg_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire ifs_pkg::ifs_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output ifs_pkg::ifs_out_t     m_data
);

    localparam int AW = $clog2(WINDOW_DEPTH);

    logic              skip_reg;
    logic              step;
    ifs_pkg::ifs_dec_t dec;
    logic [AW-1:0]     rd_addr, wr_addr;

    logic              p_valid_reg;
    ifs_pkg::ifs_dec_t p_dec_reg;
    logic [AW-1:0]     p_waddr_reg;
    logic              fwd_reg;
    logic [7:0]        fwd_data_reg;
    logic [7:0]        rdata;
    logic [7:0]        p_byte;
    logic              p_move;
    logic              hist_wen;

    logic              m_valid_reg;
    ifs_pkg::ifs_out_t m_data_reg;

    assign cfg_ready = 1'b1;
    assign p_move    = !m_valid_reg || m_ready;
    assign s_ready   = !p_valid_reg || p_move;
    assign step      = s_valid && s_ready;
    assign p_byte    = p_dec_reg.copy ? (fwd_reg ? fwd_data_reg : rdata) : p_dec_reg.lit_byte;
    assign hist_wen  = p_valid_reg && p_move && p_dec_reg.lit_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg <= 1'b1;
        end else if (cfg_valid) begin
            skip_reg <= cfg_data;
        end
    end

    ifs_decode #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dec (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .skip_hdr (skip_reg),
        .word_in  (s_data),
        .dec      (dec),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr)
    );

    ifs_hist #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_hist (
        .aclk  (aclk),
        .wen   (hist_wen),
        .waddr (p_waddr_reg),
        .wdata (p_byte),
        .ren   (step && dec.copy),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (step) begin
            p_valid_reg <= 1'b1;
        end else if (p_move) begin
            p_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            p_dec_reg    <= dec;
            p_waddr_reg  <= wr_addr;
            fwd_reg      <= hist_wen && (p_waddr_reg == rd_addr);
            fwd_data_reg <= p_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p_move) begin
            m_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_move && p_valid_reg) begin
            m_data_reg.out_valid   <= p_dec_reg.lit_valid;
            m_data_reg.out_byte    <= p_dec_reg.lit_valid ? p_byte : 8'd0;
            m_data_reg.byte_taken  <= p_dec_reg.taken;
            m_data_reg.stream_done <= p_dec_reg.done;
            m_data_reg.error_code  <= p_dec_reg.err;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

@@ sv/ifs_check.sv @@
`default_nettype none
module ifs_check (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire ifs_pkg::ifs_out_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.out_valid |-> m_data.out_byte == 8'd0)
        else $error("out_byte nonzero without out_valid");

    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.stream_done |-> m_data.error_code == ifs_pkg::ERR_NONE)
        else $error("done together with error");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.error_code != 3'd7)
        else $error("undefined error code");

endmodule

bind inflate_fixed_and_stored ifs_check u_ifs_check (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
